>>> design/lrd_pkg.sv
// shared types, constants and ridge test functions of the lane ridge detector
package lrd_pkg;

  localparam int SCORE_BITS  = 16;
  localparam int MAX_COLUMNS = 1024;
  localparam int COL_BITS    = $clog2(MAX_COLUMNS);
  localparam int DIM_BITS    = 11;
  localparam int STORE_ROWS  = 4;
  localparam int WIN         = 5;
  localparam int STORE_W     = STORE_ROWS * SCORE_BITS;
  localparam int MAX_RESULTS = 3;

  localparam logic [SCORE_BITS-1:0] THRESHOLD_RESET = SCORE_BITS'(50000);
  localparam logic [DIM_BITS-1:0]   DIM_MIN         = DIM_BITS'(3);
  localparam logic [DIM_BITS-1:0]   ROWS_MAX        = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0]   COLS_MAX        =
    DIM_BITS'((MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024);
  localparam logic [DIM_BITS-1:0]   DIM_RESET       = DIM_BITS'(1024);

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_COLS      = 2'd2;

  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [WIN-1:0][WIN-1:0][SCORE_BITS-1:0] window_t;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic        hit;
    logic [15:0] score;
    logic        last;
  } result_t;

  function automatic score_t win_at(window_t w, int wy, int wx);
    score_t v;
    v = '0;
    if (wy >= 0 && wy < WIN && wx >= 0 && wx < WIN) v = w[wy][wx];
    return v;
  endfunction

  function automatic logic dir_ok(window_t w, int cx, int dy, int dx);
    score_t v;
    logic   ok;
    v  = w[2][cx];
    ok = 1'b1;
    for (int k = 1; k <= 2; k++) begin
      if (!(v > win_at(w, 2 + k * dy, cx + k * dx))) ok = 1'b0;
      if (!(v > win_at(w, 2 - k * dy, cx - k * dx))) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic is_ridge(window_t w, int cx, score_t thr);
    score_t v;
    v = w[2][cx];
    return (v > thr) && (dir_ok(w, cx, 1, 0) || dir_ok(w, cx, 0, 1) ||
                         dir_ok(w, cx, 1, 1) || dir_ok(w, cx, 1, -1));
  endfunction

endpackage

>>> design/lane_ridge_detector_5x5_top.sv
// throughput: one pixel per cycle; a last column yields three results,
//   and the next row's first two columns yield none, so only out_tready holds the input
// a line-store read is issued on each take; the store is written when stage one advances
// reset (synchronous): threshold 50000, frame 1024x1024, scan position and window
//   cleared; line stores are not cleared, rows above the frame are masked to zero
module lane_ridge_detector_5x5_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pixel_score
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // centre_row, centre_column, centre_score, zero pad
  output logic        out_tuser,  // is_lane_centre
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lrd_pkg::*;

  score_t                thr_r;
  logic [DIM_BITS-1:0]   rows_r;
  logic [DIM_BITS-1:0]   cols_r;
  logic [DIM_BITS-1:0]   eff_rows;
  logic [DIM_BITS-1:0]   eff_cols;
  logic                  cfg_wr;
  logic                  dim_wr;

  logic [DIM_BITS-1:0]   scan_row_r, scan_row_nxt;
  logic [COL_BITS-1:0]   scan_col_r, scan_col_nxt;
  logic                  in_accept;
  logic                  take;
  logic                  in_frame;

  logic                  s1_v_r;
  score_t                s1_px_r;
  logic [DIM_BITS-1:0]   s1_row_r;
  logic [COL_BITS-1:0]   s1_col_r;
  logic                  s1_adv;

  logic [STORE_W-1:0]    rd_word;
  logic [STORE_W-1:0]    wr_word;
  score_t [WIN-1:0]      col_new;
  window_t               win_r, win_nxt;
  logic [2:0]            hit;

  logic                  yc_ok;
  logic                  first;
  logic                  tail;
  logic [1:0]            n_res;
  logic                  q_free;
  result_t [MAX_RESULTS-1:0] res;
  result_t               head;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign dim_wr     = cfg_wr && (cfg_paddr[3:2] == REG_ROWS || cfg_paddr[3:2] == REG_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RESET;
      rows_r <= DIM_RESET;
      cols_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_THRESHOLD: thr_r  <= cfg_pwdata[SCORE_BITS-1:0];
        REG_ROWS:      rows_r <= cfg_pwdata[DIM_BITS-1:0];
        REG_COLS:      cols_r <= cfg_pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_THRESHOLD: cfg_prdata = 32'(thr_r);
      REG_ROWS:      cfg_prdata = 32'(rows_r);
      REG_COLS:      cfg_prdata = 32'(cols_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign eff_rows = (rows_r < DIM_MIN) ? DIM_MIN : (rows_r > ROWS_MAX) ? ROWS_MAX : rows_r;
  assign eff_cols = (cols_r < DIM_MIN) ? DIM_MIN : (cols_r > COLS_MAX) ? COLS_MAX : cols_r;

  // input side and scan position
  assign in_tready = !s1_v_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;
  assign in_frame  = (scan_row_r < eff_rows);
  assign take      = in_accept && !(in_frame && in_tuser);

  always_comb begin
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    if ((DIM_BITS'(scan_col_r) + DIM_BITS'(1)) >= eff_cols) begin
      scan_col_nxt = '0;
      if (({1'b0, scan_row_r} + 12'd1) >= ({1'b0, eff_rows} + 12'd2)) begin
        scan_row_nxt = '0;
      end else begin
        scan_row_nxt = scan_row_r + DIM_BITS'(1);
      end
    end else begin
      scan_col_nxt = scan_col_r + COL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || dim_wr) begin
      scan_row_r <= '0;
      scan_col_r <= '0;
    end else if (take) begin
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
    end
  end

  // stage one register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_px_r  <= in_frame ? in_tdata[SCORE_BITS-1:0] : '0;
      s1_row_r <= scan_row_r;
      s1_col_r <= scan_col_r;
    end
  end

  lrd_line_store u_store (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (scan_col_r),
    .rd_data (rd_word),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (wr_word)
  );

  // new window column, store rows outside the frame read as zero
  always_comb begin
    for (int k = 0; k < STORE_ROWS; k++) begin
      if (({1'b0, s1_row_r} + 12'(k) >= 12'(STORE_ROWS)) &&
          ({1'b0, s1_row_r} + 12'(k) < {1'b0, eff_rows} + 12'(STORE_ROWS))) begin
        col_new[k] = rd_word[k*SCORE_BITS +: SCORE_BITS];
      end else begin
        col_new[k] = '0;
      end
    end
    col_new[STORE_ROWS] = s1_px_r;
    for (int k = 0; k < STORE_ROWS; k++) begin
      wr_word[k*SCORE_BITS +: SCORE_BITS] = col_new[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN - 1; j++) begin
        win_nxt[k][j] = win_r[k][j+1];
      end
      win_nxt[k][WIN-1] = col_new[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || dim_wr) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  lrd_judge u_judge (
    .win (win_nxt),
    .col (s1_col_r),
    .thr (thr_r),
    .hit (hit)
  );

  // results of the judged row
  assign yc_ok = (s1_row_r >= DIM_BITS'(2)) &&
                 ({1'b0, s1_row_r} < {1'b0, eff_rows} + 12'd2);
  assign first = yc_ok && (s1_col_r >= COL_BITS'(2));
  assign tail  = first && ((DIM_BITS'(s1_col_r) + DIM_BITS'(1)) == eff_cols);
  assign n_res = first ? (tail ? 2'd3 : 2'd1) : 2'd0;
  assign s1_adv = s1_v_r && ((n_res == 2'd0) || q_free);

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].row   = 10'(s1_row_r - DIM_BITS'(2));
      res[i].col   = 10'(s1_col_r - COL_BITS'(2 - i));
      res[i].hit   = hit[i];
      res[i].score = 16'(win_nxt[2][2+i]);
      res[i].last  = (2'(i) == n_res - 2'd1);
    end
  end

  lrd_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv && (n_res != 2'd0)),
    .load_cnt  (n_res),
    .load_res  (res),
    .free      (q_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = {4'b0, head.score, head.col, head.row};
  assign out_tuser = head.hit;
  assign out_tlast = head.last;

endmodule

>>> design/lrd_line_store.sv
// four line stores held as one wide word per column, registered read
module lrd_line_store (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [lrd_pkg::COL_BITS-1:0] rd_addr,
  output logic [lrd_pkg::STORE_W-1:0]  rd_data,
  input  logic                         wr_en,
  input  logic [lrd_pkg::COL_BITS-1:0] wr_addr,
  input  logic [lrd_pkg::STORE_W-1:0]  wr_data
);
  import lrd_pkg::*;

  logic [STORE_W-1:0] mem [MAX_COLUMNS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/lrd_judge.sv
// ridge test of the three candidate centres in the updated window
module lrd_judge (
  input  lrd_pkg::window_t             win,
  input  logic [lrd_pkg::COL_BITS-1:0] col,
  input  lrd_pkg::score_t              thr,
  output logic [2:0]                   hit
);
  import lrd_pkg::*;

  window_t win_m;

  // columns left of the frame edge read as zero
  always_comb begin
    for (int wy = 0; wy < WIN; wy++) begin
      for (int wx = 0; wx < WIN; wx++) begin
        if ((DIM_BITS'(col) + DIM_BITS'(wx)) >= DIM_BITS'(WIN - 1)) begin
          win_m[wy][wx] = win[wy][wx];
        end else begin
          win_m[wy][wx] = '0;
        end
      end
    end
  end

  assign hit[0] = is_ridge(win_m, 2, thr);
  assign hit[1] = is_ridge(win_m, 3, thr);
  assign hit[2] = is_ridge(win_m, 4, thr);

endmodule

>>> design/lrd_result_queue.sv
// result register holding up to three results, handed out one per transaction
module lrd_result_queue (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         load,
  input  logic [1:0]                                   load_cnt,
  input  lrd_pkg::result_t [lrd_pkg::MAX_RESULTS-1:0] load_res,
  output logic                                         free,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output lrd_pkg::result_t                             head
);
  import lrd_pkg::*;

  result_t [MAX_RESULTS-1:0] q_r;
  logic [1:0]                cnt_r;
  logic                      pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign free      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign head      = q_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= load_res;
    end else if (pop) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

endmodule
